// ----- design/mbfc_pkg.sv -----
// Shared types, constants and coefficient tables for the biquad filter chain.
package mbfc_pkg;

    // Fixed field widths.
    localparam int CHAN_W  = 3;
    localparam int DLY_W   = 40;
    localparam int WORD_W  = 2 * DLY_W;
    localparam int COEF_W  = 32;
    localparam int MUL_A_W = 21;
    localparam int PROD_W  = MUL_A_W + COEF_W;
    localparam int TERM_W  = 42;
    localparam int ACC_W   = 44;
    localparam int FULL_W  = PROD_W + 20;
    localparam int STEP_W  = 4;
    localparam int ROW_W   = 3;

    typedef logic signed [DLY_W-1:0]  dly_t;
    typedef logic [WORD_W-1:0]        word_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [ROW_W-1:0]         row_t;

    // Filter sections, in cascade order.
    typedef enum logic [1:0] {
        SEC_HP,
        SEC_NOTCH,
        SEC_BP
    } sec_t;

    // Coefficient selector, in the order the products are issued.
    typedef enum logic [2:0] {
        K_B0,
        K_B1,
        K_B2,
        K_A1,
        K_A2
    } coef_sel_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // Steps of one biquad stage.
    localparam step_t STEP_INIT = 4'd1;
    localparam step_t STEP_Y    = 4'd3;
    localparam step_t STEP_D1A  = 4'd5;
    localparam step_t STEP_D2A  = 4'd7;
    localparam step_t STEP_D1B  = 4'd9;
    localparam step_t STEP_D2B  = 4'd11;
    localparam step_t STEP_WB   = 4'd12;

    // Control from the sequencer to the multiply-accumulate datapath.
    typedef struct packed {
        logic  clear;
        logic  load_x;
        logic  run;
        step_t step;
        sec_t  sec;
        row_t  row;
    } mac_ctrl_t;

    // Rounds a decimal constant scaled by 1e10 to Q2.30.
    function automatic longint q30(input longint d);
        return (d * 64'sd1048576 + 64'sd4882812) / 64'sd9765625;
    endfunction

    localparam coef_t Q_ONE     = 32'sh4000_0000;
    localparam coef_t Q_TWO_POS = 32'sh7FFF_FFFF;
    localparam coef_t Q_TWO_NEG = 32'sh8000_0000;

    // Rows hold b0, b1, b2, a1, a2.
    localparam coef_t HP_TAB [3][5] = '{
        '{coef_t'(q30(64'sd8856732902)),   coef_t'(-q30(64'sd17713465803)),
          coef_t'(q30(64'sd8856732902)),   coef_t'(-q30(64'sd18819135475)),
          coef_t'(q30(64'sd8856344163))},
        '{Q_ONE, Q_TWO_NEG, Q_ONE,
          coef_t'(-q30(64'sd19111970674)), coef_t'(q30(64'sd9149758348))},
        '{Q_ONE, Q_TWO_NEG, Q_ONE,
          coef_t'(-q30(64'sd19641335713)), coef_t'(q30(64'sd9680170033))}
    };

    localparam coef_t NOTCH_TAB [2][5] = '{
        '{coef_t'(q30(64'sd9604936210)),   coef_t'(-q30(64'sd18709906429)),
          coef_t'(q30(64'sd9604936210)),   coef_t'(-q30(64'sd18709906429)),
          coef_t'(q30(64'sd9209872420))},
        '{coef_t'(q30(64'sd9604936210)),   coef_t'(-q30(64'sd18709906429)),
          coef_t'(q30(64'sd9604936210)),   coef_t'(-q30(64'sd18709906429)),
          coef_t'(q30(64'sd9209872420))}
    };

    localparam coef_t BP_TAB [3][5] = '{
        '{coef_t'(q30(64'sd5432977372)),   coef_t'(q30(64'sd10865954745)),
          coef_t'(q30(64'sd5432977372)),   coef_t'(q30(64'sd14648681940)),
          coef_t'(q30(64'sd5402535694))},
        '{Q_ONE, Q_TWO_POS, Q_ONE,
          coef_t'(q30(64'sd15610180758)),  coef_t'(q30(64'sd6413515381))},
        '{Q_ONE, Q_TWO_POS, Q_ONE,
          coef_t'(q30(64'sd17612492291)),  coef_t'(q30(64'sd8518870319))}
    };

    // Coefficient lookup; rows beyond a section's table pass the signal through.
    function automatic coef_t coef_of(input sec_t sec, input row_t row, input coef_sel_t k);
        coef_t thru;
        coef_t c;
        thru = (k == K_B0) ? Q_ONE : '0;
        c    = thru;
        case (sec)
            SEC_HP:
            begin
                if (row < 3'd3 && k <= K_A2)
                begin
                    c = HP_TAB[row[1:0]][k];
                end
            end
            SEC_NOTCH:
            begin
                if (row < 3'd2 && k <= K_A2)
                begin
                    c = NOTCH_TAB[row[0]][k];
                end
            end
            SEC_BP:
            begin
                if (row < 3'd3 && k <= K_A2)
                begin
                    c = BP_TAB[row[1:0]][k];
                end
            end
            default:
            begin
                c = thru;
            end
        endcase
        return c;
    endfunction

    // Saturates an accumulator value to a 40-bit delay word.
    function automatic dly_t sat40(input acc_t v);
        dly_t r;
        if ((&v[ACC_W-1:DLY_W-1]) || !(|v[ACC_W-1:DLY_W-1]))
        begin
            r = v[DLY_W-1:0];
        end
        else if (v[ACC_W-1])
        begin
            r = {1'b1, {(DLY_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DLY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- design/mbfc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module mbfc_ram #(
    parameter int WIDTH  = 80,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/mbfc_mac.sv -----
// Shared multiply-accumulate datapath that evaluates one biquad stage at a time.
module mbfc_mac #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  mbfc_pkg::mac_ctrl_t           ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  mbfc_pkg::word_t               rd_data,
    output mbfc_pkg::word_t               wr_data,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int FRAC = 32 - SAMPLE_BITS;
    localparam int RW   = mbfc_pkg::DLY_W + 1;
    localparam logic signed [RW-1:0] HALF = RW'((41'd1 << FRAC) >> 1);
    localparam logic signed [RW-1:0] SMAX = (RW'(1) <<< (SAMPLE_BITS - 1)) - RW'(1);
    localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);

    mbfc_pkg::dly_t  x_reg;
    mbfc_pkg::dly_t  y_reg;
    mbfc_pkg::prod_t prod_reg;
    mbfc_pkg::prod_t lo_reg;
    mbfc_pkg::term_t term_reg;
    mbfc_pkg::acc_t  acc_d1_reg;
    mbfc_pkg::acc_t  acc_d2_reg;

    mbfc_pkg::coef_sel_t              ksel;
    mbfc_pkg::coef_t                  coef;
    mbfc_pkg::dly_t                   opnd;
    logic signed [mbfc_pkg::MUL_A_W-1:0] mul_a;
    mbfc_pkg::prod_t                  prod;
    logic signed [mbfc_pkg::FULL_W-1:0]  full;
    mbfc_pkg::term_t                  term_rnd;
    mbfc_pkg::dly_t                   d1_old;
    mbfc_pkg::dly_t                   d2_old;
    mbfc_pkg::dly_t                   x_in;
    mbfc_pkg::acc_t                   y_sum;
    logic signed [RW-1:0]             r_sum;
    logic signed [RW-1:0]             r_sh;

    assign d1_old = rd_data[mbfc_pkg::WORD_W-1:mbfc_pkg::DLY_W];
    assign d2_old = rd_data[mbfc_pkg::DLY_W-1:0];

    // Operand and coefficient select: two issue steps per product, low half first.
    always_comb
    begin
        ksel  = mbfc_pkg::coef_sel_t'(ctrl.step[3:1]);
        coef  = mbfc_pkg::coef_of(ctrl.sec, ctrl.row, ksel);
        opnd  = (ksel == mbfc_pkg::K_A1 || ksel == mbfc_pkg::K_A2) ? y_reg : x_reg;
        mul_a = ctrl.step[0] ? {opnd[mbfc_pkg::DLY_W-1], opnd[mbfc_pkg::DLY_W-1:20]}
                             : {1'b0, opnd[19:0]};
        prod  = mul_a * coef;
    end

    // Recombine the two partial products and round the Q2.30 product.
    always_comb
    begin
        full = $signed({prod_reg, 20'd0})
             + $signed({{20{lo_reg[mbfc_pkg::PROD_W-1]}}, lo_reg})
             + mbfc_pkg::FULL_W'(64'sd536870912);
        term_rnd = full[mbfc_pkg::FULL_W-2:30];
    end

    assign y_sum = mbfc_pkg::ACC_W'(term_reg) + mbfc_pkg::ACC_W'(d1_old);
    assign x_in  = {{(mbfc_pkg::DLY_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample} << FRAC;

    // Pipeline: multiplier register, partial product, rounded term, accumulators.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_x)
        begin
            x_reg <= x_in;
        end
        if (ctrl.run)
        begin
            prod_reg <= prod;
            if (ctrl.step[0])
            begin
                lo_reg <= prod_reg;
            end
            else
            begin
                term_reg <= term_rnd;
            end
            case (ctrl.step)
                mbfc_pkg::STEP_INIT:
                begin
                    acc_d1_reg <= mbfc_pkg::ACC_W'(d2_old);
                    acc_d2_reg <= '0;
                end
                mbfc_pkg::STEP_Y:
                begin
                    y_reg <= mbfc_pkg::sat40(y_sum);
                end
                mbfc_pkg::STEP_D1A, mbfc_pkg::STEP_D1B:
                begin
                    acc_d1_reg <= acc_d1_reg + mbfc_pkg::ACC_W'(term_reg);
                end
                mbfc_pkg::STEP_D2A, mbfc_pkg::STEP_D2B:
                begin
                    acc_d2_reg <= acc_d2_reg + mbfc_pkg::ACC_W'(term_reg);
                end
                mbfc_pkg::STEP_WB:
                begin
                    x_reg <= y_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // New delay words, or zeros during the clearing sweep.
    assign wr_data = ctrl.clear ? '0
                   : {mbfc_pkg::sat40(acc_d1_reg), mbfc_pkg::sat40(acc_d2_reg)};

    // Round the final stage output to the sample scale and saturate.
    always_comb
    begin
        r_sum = {x_reg[mbfc_pkg::DLY_W-1], x_reg} + HALF;
        r_sh  = r_sum >>> FRAC;
        if (r_sh > SMAX)
        begin
            result = SMAX[SAMPLE_BITS-1:0];
        end
        else if (r_sh < SMIN)
        begin
            result = SMIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = r_sh[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ----- design/mbfc_seq.sv -----
// Sequencer: clearing sweep, per-stage step control, state memory addressing and output register.
module mbfc_seq #(
    parameter int CHANNELS     = 8,
    parameter int HP_STAGES    = 3,
    parameter int BP_STAGES    = 3,
    parameter int NOTCH_STAGES = 2,
    parameter int SAMPLE_BITS  = 24,
    parameter int TOTAL        = HP_STAGES + NOTCH_STAGES + BP_STAGES,
    parameter int STAGE_W      = $clog2(TOTAL),
    parameter int DEPTH        = CHANNELS << STAGE_W,
    parameter int AW           = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [mbfc_pkg::CHAN_W-1:0]   chan,
    input  logic                          window_end,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [mbfc_pkg::CHAN_W-1:0]   chan_out,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          window_end_out,
    input  logic signed [SAMPLE_BITS-1:0] mac_result,
    output mbfc_pkg::mac_ctrl_t           ctrl,
    output logic                          ram_we,
    output logic [AW-1:0]                 ram_waddr,
    output logic                          ram_re,
    output logic [AW-1:0]                 ram_raddr
);

    localparam int AXW = AW + mbfc_pkg::CHAN_W;

    mbfc_pkg::seq_state_t state_reg, state_next;
    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic [STAGE_W-1:0]         stage_reg, stage_next;
    mbfc_pkg::step_t            step_reg, step_next;
    logic [mbfc_pkg::CHAN_W-1:0] chan_reg, chan_next;
    logic                       wend_reg, wend_next;
    logic                       skip_reg, skip_next;
    logic                       out_valid_reg, out_valid_next;
    logic [mbfc_pkg::CHAN_W-1:0] out_chan_reg, out_chan_next;
    logic signed [SAMPLE_BITS-1:0] out_filt_reg, out_filt_next;
    logic                       out_wend_reg, out_wend_next;

    logic          chan_ok;
    logic          stage_last;
    logic          clr_last;
    logic          out_free;
    logic          accept;
    logic          out_load;
    logic [AXW-1:0] addr_wide;
    logic [AW-1:0]  addr;
    mbfc_pkg::sec_t stage_sec;
    mbfc_pkg::row_t stage_row;

    assign chan_ok    = 32'(chan) < CHANNELS;
    assign stage_last = 32'(stage_reg) == TOTAL - 1;
    assign clr_last   = clr_addr_reg == AW'(DEPTH - 1);
    assign out_free   = !out_valid_reg || !result_stall;
    assign addr_wide  = (AXW'(chan_reg) << STAGE_W) | AXW'(stage_reg);
    assign addr       = addr_wide[AW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbfc_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = mbfc_pkg::ST_IDLE;
                end
            end
            mbfc_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = chan_ok ? mbfc_pkg::ST_RUN : mbfc_pkg::ST_DONE;
                end
            end
            mbfc_pkg::ST_RUN:
            begin
                if (step_reg == mbfc_pkg::STEP_WB && stage_last)
                begin
                    state_next = mbfc_pkg::ST_DONE;
                end
            end
            mbfc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mbfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbfc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs: handshake, memory port and datapath control.
    always_comb
    begin
        sample_stall = 1'b1;
        accept       = 1'b0;
        out_load     = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = addr;
        ram_raddr    = addr;
        ctrl.clear   = 1'b0;
        ctrl.run     = 1'b0;
        case (state_reg)
            mbfc_pkg::ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = clr_addr_reg;
                ctrl.clear = 1'b1;
            end
            mbfc_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                accept       = sample_valid;
            end
            mbfc_pkg::ST_RUN:
            begin
                ctrl.run = 1'b1;
                ram_re   = 1'b1;
                ram_we   = step_reg == mbfc_pkg::STEP_WB;
            end
            mbfc_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
        ctrl.load_x = accept;
        ctrl.step   = step_reg;
        ctrl.sec    = stage_sec;
        ctrl.row    = stage_row;
    end

    // Section and row of the current stage.
    always_comb
    begin
        if (32'(stage_reg) < HP_STAGES)
        begin
            stage_sec = mbfc_pkg::SEC_HP;
            stage_row = mbfc_pkg::ROW_W'(32'(stage_reg));
        end
        else if (32'(stage_reg) < HP_STAGES + NOTCH_STAGES)
        begin
            stage_sec = mbfc_pkg::SEC_NOTCH;
            stage_row = mbfc_pkg::ROW_W'(32'(stage_reg) - HP_STAGES);
        end
        else
        begin
            stage_sec = mbfc_pkg::SEC_BP;
            stage_row = mbfc_pkg::ROW_W'(32'(stage_reg) - HP_STAGES - NOTCH_STAGES);
        end
    end

    // Counters, item registers and the output register.
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        stage_next     = stage_reg;
        step_next      = step_reg;
        chan_next      = chan_reg;
        wend_next      = wend_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        out_chan_next  = out_chan_reg;
        out_filt_next  = out_filt_reg;
        out_wend_next  = out_wend_reg;

        if (state_reg == mbfc_pkg::ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (accept)
        begin
            chan_next  = chan;
            wend_next  = window_end;
            skip_next  = !chan_ok;
            stage_next = '0;
            step_next  = '0;
        end
        else if (state_reg == mbfc_pkg::ST_RUN)
        begin
            if (step_reg == mbfc_pkg::STEP_WB)
            begin
                step_next  = '0;
                stage_next = stage_reg + STAGE_W'(1);
            end
            else
            begin
                step_next = step_reg + mbfc_pkg::STEP_W'(1);
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_chan_next  = chan_reg;
            out_filt_next  = skip_reg ? '0 : mac_result;
            out_wend_next  = wend_reg;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbfc_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            stage_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            stage_reg     <= stage_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chan_reg     <= chan_next;
        wend_reg     <= wend_next;
        skip_reg     <= skip_next;
        out_chan_reg <= out_chan_next;
        out_filt_reg <= out_filt_next;
        out_wend_reg <= out_wend_next;
    end

    assign result_valid   = out_valid_reg;
    assign chan_out       = out_chan_reg;
    assign filtered       = out_filt_reg;
    assign window_end_out = out_wend_reg;

endmodule

// ----- design/multichannel_biquad_filter_chain.sv -----
// Top level of the multichannel biquad filter chain.
//
//  Channel  Handshake                    Beat fields
//  -------  ---------------------------  ------------------------------------
//  sample   sample_valid / sample_stall  chan, sample_in, window_end
//  result   result_valid / result_stall  chan_out, filtered, window_end_out
//
// Each biquad stage runs on the shared 21x32 multiplier as five products of two partial
// products each, plus drain and write-back. A beat in range runs through all
// HP_STAGES + NOTCH_STAGES + BP_STAGES stages; a beat whose channel is out of range
// skips the stages and yields zero.
// After reset a sweep over all CHANNELS * 2**ceil(log2(stages)) entries (64 by default)
// zeroes the delay memory; sample_stall stays high until it ends.
// A finished beat waits in the output register while the next sample is accepted.
module multichannel_biquad_filter_chain #(
    parameter int CHANNELS     = 8,
    parameter int HP_STAGES    = 3,
    parameter int BP_STAGES    = 3,
    parameter int NOTCH_STAGES = 2,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [2:0]                    chan,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          window_end,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [2:0]                    chan_out,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          window_end_out
);

    localparam int TOTAL   = HP_STAGES + NOTCH_STAGES + BP_STAGES;
    localparam int STAGE_W = $clog2(TOTAL);
    localparam int DEPTH   = CHANNELS << STAGE_W;
    localparam int AW      = $clog2(DEPTH);

    mbfc_pkg::mac_ctrl_t           ctrl;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    mbfc_pkg::word_t               ram_wdata;
    mbfc_pkg::word_t               ram_rdata;
    logic signed [SAMPLE_BITS-1:0] mac_result;

    // Sequencer and output register.
    mbfc_seq #(
        .CHANNELS     (CHANNELS),
        .HP_STAGES    (HP_STAGES),
        .BP_STAGES    (BP_STAGES),
        .NOTCH_STAGES (NOTCH_STAGES),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .chan           (chan),
        .window_end     (window_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .chan_out       (chan_out),
        .filtered       (filtered),
        .window_end_out (window_end_out),
        .mac_result     (mac_result),
        .ctrl           (ctrl),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr)
    );

    // Multiply-accumulate datapath.
    mbfc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk     (clk),
        .ctrl    (ctrl),
        .sample  (sample_in),
        .rd_data (ram_rdata),
        .wr_data (ram_wdata),
        .result  (mac_result)
    );

    // Delay word memory: one entry of (d1, d2) per channel and stage.
    mbfc_ram #(
        .WIDTH (mbfc_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- dv/multichannel_biquad_filter_chain_tb.sv -----
// Self-checking testbench for the multichannel biquad filter chain, with its own cascade predictor.
`timescale 1ns / 1ps

module multichannel_biquad_filter_chain_tb;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_W    = 24;
    localparam int DLY_BITS    = 40;
    localparam int FRAC        = 32 - SAMPLE_W;
    localparam int STAGES      = 8;
    localparam int DIR_ROWS    = 20;
    localparam int RAND_ITEMS  = 800;
    localparam int HOLD_CYCLES = 500;
    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;

    // Coefficient positions within one stage row.
    localparam int TAP_B0 = 0;
    localparam int TAP_B1 = 1;
    localparam int TAP_B2 = 2;
    localparam int TAP_A1 = 3;
    localparam int TAP_A2 = 4;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

    // Shapes of the random sample bursts.
    typedef enum int {
        BURST_NOISE,
        BURST_QUIET,
        BURST_RAIL,
        BURST_TOGGLE,
        BURST_STEP
    } burst_t;

    // One result beat as the filter should deliver it.
    typedef struct packed {
        logic [2:0]                   ch;
        logic signed [SAMPLE_W-1:0]   value;
        logic                         we;
    } filter_beat_t;

    // One directed stimulus row; typed rows carry a known output.
    typedef struct packed {
        logic [2:0]                   ch;
        logic signed [SAMPLE_W-1:0]   smp;
        logic                         we;
        logic                         typed;
        logic signed [SAMPLE_W-1:0]   want;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         sample_valid;
    logic                         sample_stall;
    logic [2:0]                   chan;
    logic signed [SAMPLE_W-1:0]   sample_in;
    logic                         window_end;
    logic                         result_valid;
    logic                         result_stall;
    logic [2:0]                   chan_out;
    logic signed [SAMPLE_W-1:0]   filtered;
    logic                         window_end_out;

    longint       coef_tab [STAGES][5];
    longint       delay_mem [CHANNELS][STAGES][2];
    filter_beat_t pending_q [$];
    int           err_count;
    int           idle_cycles;
    bit           quiet;
    bit           hold_req;

    // Fresh channels fed with zero must give zero; the rest goes to the predictor.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{3'd0, 24'sh000000, 1'b0, 1'b1, 24'sh000000},
        '{3'd7, 24'sh000000, 1'b1, 1'b1, 24'sh000000},
        '{3'd1, S_MAX,       1'b0, 1'b0, 24'sh000000},
        '{3'd1, S_MAX,       1'b0, 1'b0, 24'sh000000},
        '{3'd1, S_MAX,       1'b1, 1'b0, 24'sh000000},
        '{3'd2, S_MIN,       1'b0, 1'b0, 24'sh000000},
        '{3'd2, S_MIN,       1'b0, 1'b0, 24'sh000000},
        '{3'd2, S_MIN,       1'b1, 1'b0, 24'sh000000},
        '{3'd3, 24'sh000001, 1'b0, 1'b0, 24'sh000000},
        '{3'd3, 24'shFFFFFF, 1'b0, 1'b0, 24'sh000000},
        '{3'd3, 24'sh000001, 1'b1, 1'b0, 24'sh000000},
        '{3'd4, S_MAX,       1'b0, 1'b0, 24'sh000000},
        '{3'd4, S_MIN,       1'b0, 1'b0, 24'sh000000},
        '{3'd4, S_MAX,       1'b0, 1'b0, 24'sh000000},
        '{3'd4, S_MIN,       1'b1, 1'b0, 24'sh000000},
        '{3'd5, 24'sh555555, 1'b0, 1'b0, 24'sh000000},
        '{3'd5, 24'shAAAAAA, 1'b1, 1'b0, 24'sh000000},
        '{3'd6, 24'sh000000, 1'b0, 1'b1, 24'sh000000},
        '{3'd6, 24'sh400000, 1'b1, 1'b0, 24'sh000000},
        '{3'd0, 24'sh000000, 1'b1, 1'b1, 24'sh000000}
    };

    multichannel_biquad_filter_chain dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .chan           (chan),
        .sample_in      (sample_in),
        .window_end     (window_end),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .chan_out       (chan_out),
        .filtered       (filtered),
        .window_end_out (window_end_out)
    );

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Decimal constant scaled by 1e10, rounded to Q2.30.
    function automatic longint q30_of(input longint d);
        return (d * 1048576 + 4882812) / 9765625;
    endfunction

    // Round-to-nearest product of a 40-bit signal and a Q2.30 coefficient.
    function automatic longint q30_product(input longint v, input longint c);
        logic signed [79:0] p;
        p = v;
        p = p * c;
        p = (p + 80'sd536870912) >>> 30;
        return longint'(p);
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint top;
        top = (64'sd1 <<< (bits - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    // Runs one sample through the channel's eight-stage cascade and updates its delays.
    function automatic logic signed [SAMPLE_W-1:0] run_chain(
        input logic [2:0] ch, input logic signed [SAMPLE_W-1:0] smp);
        longint x;
        longint y;
        longint n1;
        longint n2;
        longint r;
        int     st;
        // A channel beyond the configured count leaves state alone and yields zero.
        if (ch >= CHANNELS)
            return '0;
        x = longint'(smp) * (64'sd1 <<< FRAC);
        for (st = 0; st < STAGES; st++)
        begin
            y  = clamp(q30_product(x, coef_tab[st][TAP_B0]) + delay_mem[ch][st][0], DLY_BITS);
            n1 = clamp(q30_product(x, coef_tab[st][TAP_B1]) + q30_product(y, coef_tab[st][TAP_A1])
                       + delay_mem[ch][st][1], DLY_BITS);
            n2 = clamp(q30_product(x, coef_tab[st][TAP_B2]) + q30_product(y, coef_tab[st][TAP_A2]),
                       DLY_BITS);
            delay_mem[ch][st][0] = n1;
            delay_mem[ch][st][1] = n2;
            x = y;
        end
        r = (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        r = clamp(r, SAMPLE_W);
        return r[SAMPLE_W-1:0];
    endfunction

    // Mostly short idle runs, now and then a long one.
    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    // Offers one sample beat, waits for it to be taken, and records the expected result.
    task automatic send_sample(input logic [2:0] ch, input logic signed [SAMPLE_W-1:0] smp,
                               input logic we, input logic typed,
                               input logic signed [SAMPLE_W-1:0] typed_val);
        filter_beat_t beat;
        int           pause;
        chan         <= ch;
        sample_in    <= smp;
        window_end   <= we;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (!(sample_valid && !sample_stall))
            @(posedge clk);
        beat.ch    = ch;
        beat.we    = we;
        beat.value = run_chain(ch, smp);
        if (typed)
            beat.value = typed_val;
        pending_q.push_back(beat);
        pause = (quiet || hold_req || $urandom_range(0, 99) < 60) ? 0 : pick_pause();
        if (pause > 0)
        begin
            sample_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // Coefficient rows: three highpass, two notch, three bandpass.
    initial
    begin
        coef_tab[0] = '{q30_of(64'sd8856732902), -q30_of(64'sd17713465803),
                        q30_of(64'sd8856732902), -q30_of(64'sd18819135475),
                        q30_of(64'sd8856344163)};
        coef_tab[1] = '{64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
                        -q30_of(64'sd19111970674), q30_of(64'sd9149758348)};
        coef_tab[2] = '{64'sd1073741824, -64'sd2147483648, 64'sd1073741824,
                        -q30_of(64'sd19641335713), q30_of(64'sd9680170033)};
        coef_tab[3] = '{q30_of(64'sd9604936210), -q30_of(64'sd18709906429),
                        q30_of(64'sd9604936210), -q30_of(64'sd18709906429),
                        q30_of(64'sd9209872420)};
        coef_tab[4] = coef_tab[3];
        coef_tab[5] = '{q30_of(64'sd5432977372), q30_of(64'sd10865954745),
                        q30_of(64'sd5432977372), q30_of(64'sd14648681940),
                        q30_of(64'sd5402535694)};
        // A coefficient of +2.0 saturates to the largest Q2.30 value.
        coef_tab[6] = '{64'sd1073741824, 64'sd2147483647, 64'sd1073741824,
                        q30_of(64'sd15610180758), q30_of(64'sd6413515381)};
        coef_tab[7] = '{64'sd1073741824, 64'sd2147483647, 64'sd1073741824,
                        q30_of(64'sd17612492291), q30_of(64'sd8518870319)};
        foreach (delay_mem[c, s, k])
            delay_mem[c][s][k] = 0;
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial
    begin : result_sink
        int stall_run;
        result_stall = 1'b0;
        stall_run    = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                stall_run = HOLD_CYCLES;
            end
            else if (stall_run == 0 && !quiet && $urandom_range(0, 7) == 0)
            begin
                stall_run = pick_pause();
            end
            if (stall_run > 0)
            begin
                result_stall <= 1'b1;
                stall_run--;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        filter_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing pending: chan %0d value %0d",
                                          chan_out, filtered));
            end
            else
            begin
                want = pending_q.pop_front();
                if (chan_out !== want.ch)
                    report_mismatch($sformatf("chan_out got %0d want %0d", chan_out, want.ch));
                if (filtered !== want.value)
                    report_mismatch($sformatf("filtered on chan %0d got %0d want %0d",
                                              want.ch, filtered, want.value));
                if (window_end_out !== want.we)
                    report_mismatch($sformatf("window_end_out got %0b want %0b",
                                              window_end_out, want.we));
            end
        end
    end

    // Count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog.
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset, directed rows, random bursts, then drain.
    initial
    begin : stimulus
        int                         i;
        int                         k;
        int                         len;
        int                         sent;
        burst_t                     mode;
        logic [2:0]                 ch;
        logic signed [SAMPLE_W-1:0] smp;
        logic signed [SAMPLE_W-1:0] level;
        logic                       we;
        err_count    = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        chan         = '0;
        sample_in    = '0;
        window_end   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. With eight channels every channel number is in range.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            send_sample(dir_rows[i].ch, dir_rows[i].smp, dir_rows[i].we,
                        dir_rows[i].typed, dir_rows[i].want);
        end

        // Random bursts per channel; rails and toggles push the stages into saturation.
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            ch    = 3'($urandom_range(0, CHANNELS - 1));
            mode  = burst_t'($urandom_range(BURST_NOISE, BURST_STEP));
            len   = $urandom_range(1, 16);
            level = SAMPLE_W'($urandom());
            for (k = 0; k < len && sent < RAND_ITEMS; k++)
            begin
                case (mode)
                    BURST_NOISE:
                    begin
                        ch  = 3'($urandom_range(0, CHANNELS - 1));
                        smp = SAMPLE_W'($urandom());
                    end
                    BURST_QUIET:  smp = SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
                    BURST_RAIL:   smp = level[0] ? S_MAX : S_MIN;
                    BURST_TOGGLE: smp = k[0] ? S_MAX : S_MIN;
                    default:      smp = level;
                endcase
                we    = (k == len - 1) || ($urandom_range(0, 15) == 0);
                quiet = (sent >= 150 && sent < 250) || (sent >= 400 && sent < 470);
                if (sent == 405)
                    hold_req = 1'b1;
                send_sample(ch, smp, we, 1'b0, '0);
                sent++;
            end
        end
        quiet        = 1'b0;
        sample_valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mbfc_pkg.sv
design/mbfc_ram.sv
design/mbfc_mac.sv
design/mbfc_seq.sv
design/multichannel_biquad_filter_chain.sv
dv/multichannel_biquad_filter_chain_tb.sv
